// ===== design/ffca_pkg.sv =====
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and constants of the first-fit coalescing allocator: field
// widths, command and status codes, request and response payloads.
// ----------------------------------------------------------------------------
package ffca_pkg;

   localparam int WORD_W = 17;   // arena word, chunk sizes and links
   localparam int EXT_W  = 19;   // byte offsets with header and size added
   localparam int ADDR_W = 48;   // absolute addresses

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [EXT_W-1:0]  off_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [1:0]        cmd_type;
   typedef logic [1:0]        status_type;

   localparam cmd_type CMD_ALLOC  = 2'd0;
   localparam cmd_type CMD_FREE   = 2'd1;
   localparam cmd_type CMD_EXTEND = 2'd2;
   localparam cmd_type CMD_INIT   = 2'd3;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_NOSPACE = 2'd1;
   localparam status_type ST_CORRUPT = 2'd2;
   localparam status_type ST_RANGE   = 2'd3;

   // configuration register indexes
   localparam logic CSR_BASE_ADDRESS = 1'b0;
   localparam logic CSR_INITIAL_SIZE = 1'b1;

   // chunk header size in bytes
   localparam off_type HDR_BYTES = 19'd16;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] request_size;
      logic [3:0]  align_log2;
      addr_type    free_address;
      addr_type    new_end;
   } req_type;

   typedef struct packed {
      status_type status;
      addr_type   alloc_address;
      addr_type   used_upper_bound;
   } rsp_type;

endpackage

// ===== design/ffca_if.sv =====
// ----------------------------------------------------------------------------
// ffca_req_if / ffca_rsp_if
// Valid/ready channels carrying allocator requests and responses.
// ----------------------------------------------------------------------------
interface ffca_req_if import ffca_pkg::*; ();
   logic        valid;
   logic        ready;
   cmd_type     cmd;
   logic [15:0] request_size;
   logic [3:0]  align_log2;
   addr_type    free_address;
   addr_type    new_end;

   modport source (output valid, cmd, request_size, align_log2, free_address, new_end,
                   input ready);
   modport sink   (input valid, cmd, request_size, align_log2, free_address, new_end,
                   output ready);
endinterface

interface ffca_rsp_if import ffca_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   addr_type   alloc_address;
   addr_type   used_upper_bound;

   modport source (output valid, status, alloc_address, used_upper_bound, input ready);
   modport sink   (input valid, status, alloc_address, used_upper_bound, output ready);
endinterface

// ===== design/first_fit_coalescing_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator
// Heap allocator with an address-ordered coalescing free list kept in an
// arena word memory; allocate, free, extend and init commands.
// ----------------------------------------------------------------------------
//   channel   dir   handshake        contents
//   req_if    in    valid / ready    cmd, size, alignment, free address, new end
//   rsp_if    out   valid / ready    status, alloc address, used upper bound
//   csr_*     in    csr_we           base_address (0), initial_size (1)
//
// One request at a time. Every request ends with a tail walk over the free
// list; an extend that passes its address checks walks the tail twice, before
// and after its up to 3 header writes. Allocate and free walk the free list
// too, reading two words per chunk visited, with up to 5 header writes.
// The single-port read of the arena memory sets the pace of every walk.
// Reset clears the control state and the arena size; the arena is set up
// by an init request. The response register lets the next request start
// while a response waits on rsp_if.ready.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator import ffca_pkg::*; #(
   parameter int ARENA_BYTES = 65536
) (
   input  logic              clock,
   input  logic              reset,
   ffca_req_if.sink          req_if,
   ffca_rsp_if.source        rsp_if,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [ADDR_W-1:0] csr_wdata
);

   addr_type base_ff, base_in;
   word_type init_size_ff, init_size_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff;
   req_type  req;
   rsp_type  eng_result;
   logic     eng_idle, eng_done, out_free, start;

   // configuration registers
   always_comb begin
      base_in      = base_ff;
      init_size_in = init_size_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_in      = csr_wdata;
            CSR_INITIAL_SIZE: init_size_in = csr_wdata[WORD_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         init_size_ff <= 17'd4096;
      end else begin
         base_ff      <= base_in;
         init_size_ff <= init_size_in;
      end
   end

   // request side
   assign req_if.ready     = eng_idle;
   assign start            = req_if.valid && eng_idle;
   assign req.cmd          = req_if.cmd;
   assign req.request_size = req_if.request_size;
   assign req.align_log2   = req_if.align_log2;
   assign req.free_address = req_if.free_address;
   assign req.new_end      = req_if.new_end;

   ffca_engine #(.ARENA_BYTES(ARENA_BYTES)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req),
      .base       ({base_ff[ADDR_W-1:3], 3'b000}),
      .init_size  (init_size_ff),
      .idle       (eng_idle),
      .done_valid (eng_done),
      .done_ack   (out_free),
      .result     (eng_result)
   );

   // response register
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign rsp_valid_in = eng_done || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_done && out_free) begin
         rsp_ff <= eng_result;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.status           = rsp_ff.status;
   assign rsp_if.alloc_address    = rsp_ff.alloc_address;
   assign rsp_if.used_upper_bound = rsp_ff.used_upper_bound;

endmodule

// ===== design/ffca_mem.sv =====
// ----------------------------------------------------------------------------
// ffca_mem
// Arena word memory: one write port, one registered read port, write data
// forwarded when both ports hit the same word in a cycle.
// ----------------------------------------------------------------------------
module ffca_mem import ffca_pkg::*; #(
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  word_type                 wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output word_type                 rd_data
);

   word_type mem [DEPTH];
   word_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port with same-word forwarding
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ffca_engine.sv =====
// ----------------------------------------------------------------------------
// ffca_engine
// Request sequencer: walks the free list in the arena memory, one word read
// per cycle, then writes back the changed headers and finds the tail chunk.
// ----------------------------------------------------------------------------
module ffca_engine import ffca_pkg::*; #(
   parameter int ARENA_BYTES = 65536
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  req_type  req,
   input  addr_type base,
   input  word_type init_size,
   output logic     idle,
   output logic     done_valid,
   input  logic     done_ack,
   output rsp_type  result
);

   localparam int WORDS = ARENA_BYTES / 8;
   localparam int AW    = $clog2(WORDS);

   typedef enum logic [17:0] {
      S_IDLE   = 18'h00001,
      S_PRE    = 18'h00002,
      S_CHK    = 18'h00004,
      S_ACUR   = 18'h00008,
      S_ASIZE  = 18'h00010,
      S_ANEXT  = 18'h00020,
      S_FCS    = 18'h00040,
      S_FNP    = 18'h00080,
      S_FP0    = 18'h00100,
      S_FCUR   = 18'h00200,
      S_FCSZ   = 18'h00400,
      S_FDEC   = 18'h00800,
      S_TSTART = 18'h01000,
      S_TNXT   = 18'h02000,
      S_TLINK  = 18'h04000,
      S_TEND   = 18'h08000,
      S_WR     = 18'h10000,
      S_DONE   = 18'h20000
   } state_type;

   typedef enum logic [2:0] {
      WK_INIT, WK_ALLOC, WK_F_BOTH, WK_F_PREV, WK_F_CUR, WK_F_NONE, WK_E_GROW, WK_E_APP
   } wkind_type;

   function automatic logic link_ok(word_type lo, word_type hi, word_type size,
                                    word_type lim);
      return (hi > lo) && ((off_type'(hi) + HDR_BYTES + off_type'(size)) <= off_type'(lim));
   endfunction

   function automatic logic in_arena(off_type off);
      return 32'(off[EXT_W-1:3]) < WORDS;
   endfunction

   state_type   state_ff, state_in;
   wkind_type   wkind_ff, wkind_in;
   cmd_type     cmd_ff, cmd_in;
   status_type  status_ff, status_in;
   word_type    sz_ff, sz_in;
   logic [15:0] almask_ff, almask_in;
   addr_type    addr_ff, addr_in;
   addr_type    off_ff, off_in;
   logic        lt_ff, lt_in;
   word_type    as_ff, as_in;
   word_type    prev_ff, prev_in;
   word_type    cur_ff, cur_in;
   word_type    psize_ff, psize_in;
   word_type    cursz_ff, cursz_in;
   word_type    csize_ff, csize_in;
   word_type    np_ff, np_in;
   word_type    cn_ff, cn_in;
   logic [15:0] pad_ff, pad_in;
   logic [17:0] need_ff, need_in;
   logic        split_ff, split_in;
   addr_type    alloc_ff, alloc_in;
   addr_type    ub_ff, ub_in;
   logic        ext_ff, ext_in;
   logic [2:0]  wstep_ff, wstep_in;
   logic        rd_oob_ff;

   off_type     rd_off, wr_off, end_prev, end_np, rem_off, cp_off;
   word_type    wr_val, rdat, mem_q, init_trunc, init_clamp;
   logic        wr_last, wr_en, link_c, link_t, ins, grow_c, fit;
   logic [17:0] need_c;
   logic [15:0] st16, pad_c;
   logic [48:0] diff;

   // arena memory
   ffca_mem #(.DEPTH(WORDS)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(wr_off[EXT_W-1:3])),
      .wr_data (wr_val),
      .rd_addr (AW'(rd_off[EXT_W-1:3])),
      .rd_data (mem_q)
   );

   // words beyond the arena read as zero
   assign rdat = rd_oob_ff ? '0 : mem_q;

   // shared datapath terms
   assign link_c     = link_ok(prev_ff, cur_ff, rdat, as_ff);
   assign link_t     = link_ok(cur_ff, cn_ff, rdat, as_ff);
   assign st16       = base[15:0] + cur_ff[15:0] + 16'd16;
   assign pad_c      = (16'd0 - st16) & almask_ff;
   assign need_c     = 18'(pad_ff) + 18'(sz_ff);
   assign fit        = 18'(csize_ff) >= need_c;
   assign end_prev   = off_type'(prev_ff) + HDR_BYTES + off_type'(psize_ff);
   assign end_np     = off_type'(np_ff) + HDR_BYTES + off_type'(csize_ff);
   assign ins        = (prev_ff < np_ff) && ((cur_ff == '0) || (np_ff < cur_ff));
   assign grow_c     = (off_type'(cur_ff) + off_type'(rdat) + HDR_BYTES) == off_type'(as_ff);
   assign diff       = {1'b0, addr_ff} - {1'b0, base};
   assign init_trunc = {init_size[WORD_W-1:3], 3'b000};
   assign init_clamp = (init_trunc < 17'd32) ? 17'd32 :
                       ((32'(init_trunc) > ARENA_BYTES) ? 17'(ARENA_BYTES) : init_trunc);
   assign rem_off    = off_type'(cur_ff) + HDR_BYTES + off_type'(need_ff);
   assign cp_off     = off_type'(cur_ff) + off_type'(pad_ff);

   // header write-back table
   always_comb begin
      wr_off  = '0;
      wr_val  = '0;
      wr_last = 1'b1;
      unique case (wkind_ff)
         WK_INIT: begin
            wr_last = (wstep_ff == 3'd3);
            unique case (wstep_ff)
               3'd0:    begin wr_off = 19'd0;  wr_val = '0;              end
               3'd1:    begin wr_off = 19'd8;  wr_val = 17'd16;          end
               3'd2:    begin wr_off = 19'd16; wr_val = sz_ff - 17'd32;  end
               default: begin wr_off = 19'd24; wr_val = '0;              end
            endcase
         end
         WK_ALLOC: begin
            wr_last = (wstep_ff == 3'd4);
            unique case (wstep_ff)
               3'd0: begin
                  wr_off = rem_off;
                  wr_val = 17'(18'(csize_ff) - need_ff - 18'd16);
               end
               3'd1: begin wr_off = rem_off + 19'd8; wr_val = cn_ff; end
               3'd2: begin
                  wr_off = off_type'(prev_ff) + 19'd8;
                  wr_val = split_ff ? rem_off[WORD_W-1:0] : cn_ff;
               end
               3'd3:    begin wr_off = cp_off;          wr_val = need_ff[WORD_W-1:0]; end
               default: begin wr_off = cp_off + 19'd8;  wr_val = cur_ff;              end
            endcase
         end
         WK_F_BOTH: begin
            wr_last = (wstep_ff == 3'd1);
            if (wstep_ff == 3'd0) begin
               wr_off = off_type'(prev_ff);
               wr_val = psize_ff + 17'd32 + csize_ff + cursz_ff;
            end else begin
               wr_off = off_type'(prev_ff) + 19'd8;
               wr_val = cn_ff;
            end
         end
         WK_F_PREV: begin
            wr_last = (wstep_ff == 3'd1);
            if (wstep_ff == 3'd0) begin
               wr_off = off_type'(prev_ff);
               wr_val = psize_ff + 17'd16 + csize_ff;
            end else begin
               wr_off = off_type'(prev_ff) + 19'd8;
               wr_val = cur_ff;
            end
         end
         WK_F_CUR: begin
            wr_last = (wstep_ff == 3'd2);
            unique case (wstep_ff)
               3'd0: begin wr_off = off_type'(np_ff); wr_val = csize_ff + 17'd16 + cursz_ff; end
               3'd1: begin wr_off = off_type'(np_ff) + 19'd8; wr_val = cn_ff; end
               default: begin wr_off = off_type'(prev_ff) + 19'd8; wr_val = np_ff; end
            endcase
         end
         WK_F_NONE: begin
            wr_last = (wstep_ff == 3'd2);
            unique case (wstep_ff)
               3'd0:    begin wr_off = off_type'(np_ff);          wr_val = csize_ff; end
               3'd1:    begin wr_off = off_type'(np_ff) + 19'd8;  wr_val = cur_ff;   end
               default: begin wr_off = off_type'(prev_ff) + 19'd8; wr_val = np_ff;   end
            endcase
         end
         WK_E_GROW: begin
            wr_off = off_type'(cur_ff);
            wr_val = cursz_ff + off_ff[WORD_W-1:0] - as_ff;
         end
         WK_E_APP: begin
            wr_last = (wstep_ff == 3'd2);
            unique case (wstep_ff)
               3'd0: begin
                  wr_off = off_type'(as_ff);
                  wr_val = off_ff[WORD_W-1:0] - as_ff - 17'd16;
               end
               3'd1:    begin wr_off = off_type'(as_ff) + 19'd8;  wr_val = '0;    end
               default: begin wr_off = off_type'(cur_ff) + 19'd8; wr_val = as_ff; end
            endcase
         end
      endcase
   end

   assign wr_en = (state_ff == S_WR) && in_arena(wr_off);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      wkind_in  = wkind_ff;
      cmd_in    = cmd_ff;
      status_in = status_ff;
      sz_in     = sz_ff;
      almask_in = almask_ff;
      addr_in   = addr_ff;
      off_in    = off_ff;
      lt_in     = lt_ff;
      as_in     = as_ff;
      prev_in   = prev_ff;
      cur_in    = cur_ff;
      psize_in  = psize_ff;
      cursz_in  = cursz_ff;
      csize_in  = csize_ff;
      np_in     = np_ff;
      cn_in     = cn_ff;
      pad_in    = pad_ff;
      need_in   = need_ff;
      split_in  = split_ff;
      alloc_in  = alloc_ff;
      ub_in     = ub_ff;
      ext_in    = ext_ff;
      wstep_in  = wstep_ff;
      rd_off    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = req.cmd;
               sz_in     = (word_type'(req.request_size) + 17'd7) & ~17'd7;
               almask_in = (req.align_log2 < 4'd3) ? 16'd7 :
                           ((16'd1 << req.align_log2) - 16'd1);
               addr_in   = (req.cmd == CMD_FREE) ? req.free_address : req.new_end;
               status_in = ST_OK;
               alloc_in  = '0;
               ext_in    = 1'b0;
               prev_in   = '0;
               unique case (req.cmd)
                  CMD_ALLOC: begin
                     rd_off   = 19'd8;
                     state_in = S_ACUR;
                  end
                  CMD_FREE, CMD_EXTEND: state_in = S_PRE;
                  default: begin
                     sz_in    = init_clamp;
                     wkind_in = WK_INIT;
                     wstep_in = '0;
                     state_in = S_WR;
                  end
               endcase
            end
         end
         // offset from base
         S_PRE: begin
            lt_in    = diff[ADDR_W];
            off_in   = diff[ADDR_W-1:0];
            state_in = S_CHK;
         end
         // address checks of free and extend
         S_CHK: begin
            state_in = S_TSTART;
            if (cmd_ff == CMD_FREE) begin
               if (addr_ff == '0) begin
                  status_in = ST_OK;
               end else if (lt_ff || (off_ff[2:0] != 3'd0) || (off_ff < 48'd32) ||
                            (off_ff > 48'(as_ff))) begin
                  status_in = ST_CORRUPT;
               end else begin
                  rd_off   = off_ff[EXT_W-1:0] - 19'd16;
                  state_in = S_FCS;
               end
            end else if (lt_ff || (off_ff[2:0] != 3'd0) || (off_ff > 48'(ARENA_BYTES)) ||
                         (as_ff < 17'd32)) begin
               status_in = ST_RANGE;
            end else begin
               ext_in = 1'b1;
            end
         end
         // free: chunk header, sentinel, first free chunk
         S_FCS: begin
            csize_in = rdat;
            rd_off   = off_ff[EXT_W-1:0] - 19'd8;
            state_in = S_FNP;
         end
         S_FNP: begin
            np_in    = rdat;
            rd_off   = '0;
            state_in = S_FP0;
         end
         S_FP0: begin
            psize_in = rdat;
            prev_in  = '0;
            rd_off   = 19'd8;
            state_in = S_FCUR;
         end
         S_FCUR: begin
            cur_in = rdat;
            if (rdat != '0) begin
               rd_off   = off_type'(rdat);
               state_in = S_FCSZ;
            end else begin
               state_in = S_FDEC;
            end
         end
         S_FCSZ: begin
            cursz_in = rdat;
            if (!link_c) begin
               status_in = ST_CORRUPT;
               state_in  = S_TSTART;
            end else begin
               rd_off   = off_type'(cur_ff) + 19'd8;
               state_in = S_FDEC;
            end
         end
         // free: insertion point and merge choice
         S_FDEC: begin
            if (ins) begin
               if ((end_prev > off_type'(np_ff)) ||
                   ((cur_ff != '0) && (end_np > off_type'(cur_ff))) ||
                   (end_np > off_type'(as_ff))) begin
                  status_in = ST_CORRUPT;
                  state_in  = S_TSTART;
               end else begin
                  cn_in    = rdat;
                  wstep_in = '0;
                  state_in = S_WR;
                  priority if ((end_prev == off_type'(np_ff)) && (prev_ff != '0) &&
                               (cur_ff != '0) && (end_np == off_type'(cur_ff))) begin
                     wkind_in = WK_F_BOTH;
                  end else if ((end_prev == off_type'(np_ff)) && (prev_ff != '0)) begin
                     wkind_in = WK_F_PREV;
                  end else if ((cur_ff != '0) && (end_np == off_type'(cur_ff))) begin
                     wkind_in = WK_F_CUR;
                  end else begin
                     wkind_in = WK_F_NONE;
                  end
               end
            end else if (cur_ff == '0) begin
               status_in = ST_CORRUPT;
               state_in  = S_TSTART;
            end else begin
               prev_in  = cur_ff;
               psize_in = cursz_ff;
               cur_in   = rdat;
               if (rdat != '0) begin
                  rd_off   = off_type'(rdat);
                  state_in = S_FCSZ;
               end else begin
                  state_in = S_FDEC;
               end
            end
         end
         // allocate: first fit walk
         S_ACUR: begin
            cur_in = rdat;
            if (rdat == '0) begin
               status_in = ST_NOSPACE;
               state_in  = S_TSTART;
            end else begin
               rd_off   = off_type'(rdat);
               state_in = S_ASIZE;
            end
         end
         S_ASIZE: begin
            csize_in = rdat;
            if (!link_c) begin
               status_in = ST_CORRUPT;
               state_in  = S_TSTART;
            end else begin
               pad_in   = pad_c;
               rd_off   = off_type'(cur_ff) + 19'd8;
               state_in = S_ANEXT;
            end
         end
         S_ANEXT: begin
            cn_in = rdat;
            if (fit) begin
               need_in  = need_c;
               alloc_in = base + 48'(off_type'(cur_ff) + HDR_BYTES + off_type'(pad_ff));
               split_in = 18'(csize_ff) > (need_c + 18'd16);
               wstep_in = (18'(csize_ff) > (need_c + 18'd16)) ? 3'd0 : 3'd2;
               wkind_in = WK_ALLOC;
               state_in = S_WR;
            end else begin
               prev_in = cur_ff;
               cur_in  = rdat;
               if (rdat == '0) begin
                  status_in = ST_NOSPACE;
                  state_in  = S_TSTART;
               end else begin
                  rd_off   = off_type'(rdat);
                  state_in = S_ASIZE;
               end
            end
         end
         // header write-back, one word a cycle
         S_WR: begin
            wstep_in = wstep_ff + 3'd1;
            if (wr_last) begin
               if (wkind_ff == WK_INIT) begin
                  as_in = sz_ff;
               end else if ((wkind_ff == WK_E_GROW) || (wkind_ff == WK_E_APP)) begin
                  as_in = off_ff[WORD_W-1:0];
               end
               state_in = S_TSTART;
            end
         end
         // tail walk
         S_TSTART: begin
            cur_in   = '0;
            rd_off   = 19'd8;
            state_in = S_TNXT;
         end
         S_TNXT: begin
            cn_in = rdat;
            if (rdat == '0) begin
               rd_off   = off_type'(cur_ff);
               state_in = S_TEND;
            end else begin
               rd_off   = off_type'(rdat);
               state_in = S_TLINK;
            end
         end
         S_TLINK: begin
            if (!link_t) begin
               if (ext_ff) begin
                  status_in = ST_CORRUPT;
                  ext_in    = 1'b0;
                  state_in  = S_TSTART;
               end else begin
                  ub_in    = base + 48'(as_ff);
                  state_in = S_DONE;
               end
            end else begin
               cur_in   = cn_ff;
               rd_off   = off_type'(cn_ff) + 19'd8;
               state_in = S_TNXT;
            end
         end
         S_TEND: begin
            cursz_in = rdat;
            if (ext_ff) begin
               ext_in   = 1'b0;
               wstep_in = '0;
               if (grow_c) begin
                  if (off_ff < 48'(as_ff)) begin
                     status_in = ST_RANGE;
                     state_in  = S_TSTART;
                  end else begin
                     wkind_in = WK_E_GROW;
                     state_in = S_WR;
                  end
               end else if (off_ff < (48'(as_ff) + 48'd16)) begin
                  status_in = ST_RANGE;
                  state_in  = S_TSTART;
               end else begin
                  wkind_in = WK_E_APP;
                  state_in = S_WR;
               end
            end else begin
               ub_in    = base + (grow_c ? 48'(off_type'(cur_ff) + HDR_BYTES) : 48'(as_ff));
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (done_ack) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         as_ff    <= '0;
      end else begin
         state_ff <= state_in;
         as_ff    <= as_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      wkind_ff  <= wkind_in;
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      sz_ff     <= sz_in;
      almask_ff <= almask_in;
      addr_ff   <= addr_in;
      off_ff    <= off_in;
      lt_ff     <= lt_in;
      prev_ff   <= prev_in;
      cur_ff    <= cur_in;
      psize_ff  <= psize_in;
      cursz_ff  <= cursz_in;
      csize_ff  <= csize_in;
      np_ff     <= np_in;
      cn_ff     <= cn_in;
      pad_ff    <= pad_in;
      need_ff   <= need_in;
      split_ff  <= split_in;
      alloc_ff  <= alloc_in;
      ub_ff     <= ub_in;
      ext_ff    <= ext_in;
      wstep_ff  <= wstep_in;
      rd_oob_ff <= !in_arena(rd_off);
   end

   assign idle                    = (state_ff == S_IDLE);
   assign done_valid              = (state_ff == S_DONE);
   assign result.status           = status_ff;
   assign result.alloc_address    = alloc_ff;
   assign result.used_upper_bound = ub_ff;

endmodule

// ===== design/ffca_checker.sv =====
// ----------------------------------------------------------------------------
// ffca_port_checker
// Port-level checks of the allocator response channel.
// ----------------------------------------------------------------------------
module ffca_port_checker import ffca_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input status_type rsp_status,
   input addr_type   rsp_alloc_address,
   input addr_type   rsp_used_upper_bound
);

   // no response straight after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_alloc_address) && $stable(rsp_used_upper_bound))
      else $error("stalled response changed");

   // failed requests carry a null address
   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_alloc_address == '0)
      else $error("address returned with error status");

   // handed-out addresses are at least 8-byte aligned
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alloc_address[2:0] == 3'd0)
      else $error("misaligned allocation");

endmodule

bind first_fit_coalescing_allocator ffca_port_checker u_ffca_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_if.valid),
   .rsp_ready            (rsp_if.ready),
   .rsp_status           (rsp_if.status),
   .rsp_alloc_address    (rsp_if.alloc_address),
   .rsp_used_upper_bound (rsp_if.used_upper_bound)
);

// ===== bench/ffca_checker.sv =====
// ----------------------------------------------------------------------------
// ffca_checker
// Watches the request, response and register ports of the allocator, keeps
// its own copy of the arena and free list, predicts each response and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module ffca_checker import ffca_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   ffca_req_if               req_if,
   ffca_rsp_if               rsp_if,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [ADDR_W-1:0] csr_wdata,
   output int                fail_count,
   output int                pending,
   output int                checked
);

   localparam int unsigned HEAP_BYTES = 65536;
   localparam int unsigned HEAP_WORDS = HEAP_BYTES / 8;
   localparam int unsigned HDR = 16;
   localparam longint unsigned ADDR_MASK = 64'h0000_FFFF_FFFF_FFFF;

   // shadow of the arena and the registers
   word_type  heap_mem [HEAP_WORDS];
   word_type  heap_size;
   addr_type  base_reg;
   word_type  init_size_reg;

   rsp_type   expected_rsp [$];

   function automatic int unsigned heap_rd(int unsigned off);
      int unsigned w;
      w = off >> 3;
      return (w < HEAP_WORDS) ? int'(heap_mem[w]) : 0;
   endfunction

   function automatic void heap_wr(int unsigned off, longint unsigned v);
      int unsigned w;
      w = off >> 3;
      if (w < HEAP_WORDS) heap_mem[w] = v[WORD_W-1:0];
   endfunction

   function automatic longint unsigned base_abs();
      return longint'(base_reg) & 64'h0000_FFFF_FFFF_FFF8;
   endfunction

   // a forward link to a chunk wholly inside the arena
   function automatic bit link_sound(int unsigned cur, int unsigned nxt);
      if (nxt <= cur) return 0;
      if (nxt + HDR > heap_size) return 0;
      return (nxt + HDR + heap_rd(nxt) <= heap_size);
   endfunction

   function automatic bit walk_to_tail(output int unsigned tail);
      int unsigned cur, nxt;
      cur = 0;
      tail = 0;
      while (1) begin
         nxt = heap_rd(cur + 8);
         if (nxt == 0) break;
         if (!link_sound(cur, nxt)) return 0;
         cur = nxt;
      end
      tail = cur;
      return 1;
   endfunction

   function automatic status_type predict_alloc(int unsigned req, int unsigned alog,
                                                output longint unsigned addr);
      longint unsigned sz, al, st, aligned, need, csize;
      int unsigned prev, cur, cnext, pad, rem;
      addr = 0;
      sz = (longint'(req) + 7) & ~64'd7;
      al = 64'd1 << ((alog < 3) ? 3 : alog);
      prev = 0;
      cur = heap_rd(8);
      while (cur != 0) begin
         if (!link_sound(prev, cur)) return ST_CORRUPT;
         st = base_abs() + cur + HDR;
         aligned = (st + al - 1) & ~(al - 1);
         need = (aligned - st) + sz;
         csize = heap_rd(cur);
         if (csize >= need) begin
            cnext = heap_rd(cur + 8);
            pad = int'(aligned - st);
            // split only when the remainder outgrows a header
            if (csize > need + HDR) begin
               rem = cur + HDR + int'(need);
               heap_wr(rem, csize - need - HDR);
               heap_wr(rem + 8, cnext);
               heap_wr(prev + 8, rem);
            end else begin
               heap_wr(prev + 8, cnext);
            end
            heap_wr(cur + pad, need);
            heap_wr(cur + pad + 8, cur);
            addr = aligned & ADDR_MASK;
            return ST_OK;
         end
         prev = cur;
         cur = heap_rd(cur + 8);
      end
      return ST_NOSPACE;
   endfunction

   function automatic status_type predict_free(longint unsigned a);
      longint unsigned b, off, end_prev, end_np;
      int unsigned hdr, csize, np, prev, cur, cs, cn;
      bit wprev, wcur;
      b = base_abs();
      if (a == 0) return ST_OK;
      if (a < b) return ST_CORRUPT;
      off = a - b;
      if ((off & 7) != 0 || off < 2 * HDR || off > heap_size) return ST_CORRUPT;
      hdr = int'(off) - HDR;
      csize = heap_rd(hdr);
      np = heap_rd(hdr + 8);
      prev = 0;
      cur = heap_rd(8);
      while (1) begin
         if (cur != 0 && !link_sound(prev, cur)) return ST_CORRUPT;
         if (prev < np && (cur == 0 || np < cur)) begin
            end_prev = longint'(prev) + HDR + heap_rd(prev);
            end_np = longint'(np) + HDR + csize;
            if (end_prev > np) return ST_CORRUPT;
            if (cur != 0 && end_np > cur) return ST_CORRUPT;
            if (end_np > heap_size) return ST_CORRUPT;
            wprev = (end_prev == np) && (prev != 0);
            wcur = (cur != 0) && (end_np == cur);
            // coalesce with the neighbours it touches
            if (wprev && wcur) begin
               cs = heap_rd(cur);
               cn = heap_rd(cur + 8);
               heap_wr(prev, longint'(heap_rd(prev)) + 2 * HDR + csize + cs);
               heap_wr(prev + 8, cn);
            end else if (wprev) begin
               heap_wr(prev, longint'(heap_rd(prev)) + HDR + csize);
               heap_wr(prev + 8, cur);
            end else if (wcur) begin
               cs = heap_rd(cur);
               cn = heap_rd(cur + 8);
               heap_wr(np, longint'(csize) + HDR + cs);
               heap_wr(np + 8, cn);
               heap_wr(prev + 8, np);
            end else begin
               heap_wr(np, csize);
               heap_wr(np + 8, cur);
               heap_wr(prev + 8, np);
            end
            return ST_OK;
         end
         if (cur == 0) return ST_CORRUPT;
         prev = cur;
         cur = heap_rd(cur + 8);
      end
   endfunction

   function automatic status_type predict_extend(longint unsigned ne);
      longint unsigned b, noff;
      int unsigned tail;
      bit grow;
      b = base_abs();
      if (ne < b) return ST_RANGE;
      noff = ne - b;
      if ((noff & 7) != 0 || noff > HEAP_BYTES || heap_size < 2 * HDR) return ST_RANGE;
      if (!walk_to_tail(tail)) return ST_CORRUPT;
      grow = (longint'(tail) + heap_rd(tail) + HDR == heap_size);
      if (grow) begin
         if (noff < heap_size) return ST_RANGE;
         heap_wr(tail, longint'(heap_rd(tail)) + noff - heap_size);
      end else begin
         if (noff < longint'(heap_size) + HDR) return ST_RANGE;
         heap_wr(heap_size, noff - heap_size - HDR);
         heap_wr(heap_size + 8, 0);
         heap_wr(tail + 8, heap_size);
      end
      heap_size = noff[WORD_W-1:0];
      return ST_OK;
   endfunction

   function automatic void predict_init();
      int unsigned sz;
      sz = init_size_reg & ~17'd7;
      if (sz < 2 * HDR) sz = 2 * HDR;
      if (sz > HEAP_BYTES) sz = HEAP_BYTES;
      heap_wr(0, 0);
      heap_wr(8, HDR);
      heap_wr(HDR, sz - 2 * HDR);
      heap_wr(HDR + 8, 0);
      heap_size = sz[WORD_W-1:0];
   endfunction

   function automatic rsp_type predict_response(req_type r);
      rsp_type e;
      longint unsigned addr, ub;
      int unsigned tail;
      addr = 0;
      e.status = ST_OK;
      case (r.cmd)
         CMD_ALLOC:  e.status = predict_alloc(r.request_size, r.align_log2, addr);
         CMD_FREE:   e.status = predict_free(r.free_address);
         CMD_EXTEND: e.status = predict_extend(r.new_end);
         default:    predict_init();
      endcase
      if (walk_to_tail(tail) && longint'(tail) + heap_rd(tail) + HDR == heap_size)
         ub = base_abs() + tail + HDR;
      else
         ub = base_abs() + heap_size;
      e.alloc_address = addr[ADDR_W-1:0];
      e.used_upper_bound = ub[ADDR_W-1:0];
      return e;
   endfunction

   function automatic void report_mismatch(string what, longint unsigned exp_v,
                                           longint unsigned got_v);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch on response %0d: %s expected 0x%0h got 0x%0h",
                  checked, what, exp_v, got_v);
   endfunction

   // sample all ports on the rising edge, response side before request side
   always @(posedge clock) begin
      rsp_type e;
      req_type r;
      if (reset) begin
         base_reg <= '0;
         init_size_reg <= 17'd4096;
         heap_size = '0;
         expected_rsp.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected response, status", 0, rsp_if.status);
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_if.status !== e.status)
                  report_mismatch("status", e.status, rsp_if.status);
               if (rsp_if.alloc_address !== e.alloc_address)
                  report_mismatch("alloc_address", e.alloc_address, rsp_if.alloc_address);
               if (rsp_if.used_upper_bound !== e.used_upper_bound)
                  report_mismatch("used_upper_bound", e.used_upper_bound,
                                  rsp_if.used_upper_bound);
            end
            checked++;
         end
         if (req_if.valid && req_if.ready) begin
            r.cmd = req_if.cmd;
            r.request_size = req_if.request_size;
            r.align_log2 = req_if.align_log2;
            r.free_address = req_if.free_address;
            r.new_end = req_if.new_end;
            expected_rsp.push_back(predict_response(r));
         end
         if (csr_we) begin
            if (csr_index == CSR_BASE_ADDRESS) base_reg <= csr_wdata;
            else init_size_reg <= csr_wdata[WORD_W-1:0];
         end
      end
      pending <= expected_rsp.size();
   end

   initial begin
      fail_count = 0;
      checked = 0;
      pending = 0;
   end

endmodule

// ===== bench/first_fit_coalescing_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_tb
// Drives allocate, free, extend and init requests into the allocator over
// several arena settings and idling patterns; the checker beside the block
// predicts and compares every response.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator_tb;
   import ffca_pkg::*;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic              csr_index;
   logic [ADDR_W-1:0] csr_wdata;

   ffca_req_if req_bus ();
   ffca_rsp_if rsp_bus ();

   int        fail_count;
   int        pending;
   int        checked;
   int        sender_pct;
   int        receiver_pct;
   int        requests_sent;
   int        hold_left;
   bit        hold_wanted;
   bit        hold_done;
   addr_type  cur_base;
   addr_type  live_blocks [$];
   addr_type  freed_blocks [$];

   first_fit_coalescing_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ffca_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_bus),
      .rsp_if     (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always #4 clock = ~clock;

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_wanted && !hold_done) begin
         hold_left <= 400;
         hold_done <= 1'b1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_pct);
      end
   end

   // remember returned blocks so later frees hit real allocations
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready && rsp_bus.alloc_address != 0)
         live_blocks.push_back(rsp_bus.alloc_address);
   end

   task automatic send_request(cmd_type c, logic [15:0] sz, logic [3:0] al,
                               addr_type fa, addr_type ne);
      int gap;
      gap = ($urandom_range(99) < sender_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= c;
      req_bus.request_size <= sz;
      req_bus.align_log2 <= al;
      req_bus.free_address <= fa;
      req_bus.new_end <= ne;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // both registers, then a fresh layout
   task automatic set_arena(addr_type base, logic [16:0] init_sz);
      csr_we <= 1'b1;
      csr_index <= CSR_BASE_ADDRESS;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CSR_INITIAL_SIZE;
      csr_wdata <= {31'd0, init_sz};
      @(posedge clock);
      csr_we <= 1'b0;
      cur_base = base & 48'hFFFF_FFFF_FFF8;
      send_request(CMD_INIT, '0, '0, '0, '0);
      live_blocks.delete();
      freed_blocks.delete();
   endtask

   task automatic random_request();
      int pick, idx;
      logic [15:0] sz;
      logic [3:0] al;
      addr_type a;
      pick = $urandom_range(99);
      if (pick < 45) begin
         case ($urandom_range(9))
            0:       sz = 16'($urandom());
            1, 2:    sz = 16'($urandom_range(4096));
            default: sz = 16'($urandom_range(256));
         endcase
         al = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(4));
         send_request(CMD_ALLOC, sz, al, 48'($urandom()), 48'($urandom()));
      end else if (pick < 82) begin
         idx = $urandom_range(19);
         if (idx < 15 && live_blocks.size() > 0) begin
            idx = $urandom_range(live_blocks.size() - 1);
            a = live_blocks[idx];
            live_blocks.delete(idx);
            freed_blocks.push_back(a);
         end else if (idx < 17 && freed_blocks.size() > 0) begin
            // double free
            a = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
         end else begin
            // stray addresses that never reach an unlaid header
            case ($urandom_range(4))
               0: a = 48'({$urandom(), $urandom()});
               1: a = '0;
               2: a = cur_base + 48'(8 * $urandom_range(8192) + $urandom_range(1, 7));
               3: a = cur_base + 48'd32;
               default: a = cur_base + 48'(65544 + 8 * $urandom_range(64));
            endcase
         end
         send_request(CMD_FREE, 16'($urandom()), 4'($urandom()), a, 48'($urandom()));
      end else if (pick < 96) begin
         case ($urandom_range(5))
            0: a = 48'({$urandom(), $urandom()});
            1: a = cur_base + 48'($urandom_range(65600));
            default: a = cur_base + 48'(8 * $urandom_range(8192));
         endcase
         send_request(CMD_EXTEND, 16'($urandom()), 4'($urandom()), 48'($urandom()), a);
      end else begin
         send_request(CMD_INIT, 16'($urandom()), 4'($urandom()), 48'($urandom()),
                      48'($urandom()));
         live_blocks.delete();
         freed_blocks.delete();
      end
   endtask

   initial begin
      addr_type bases [6];
      logic [16:0] sizes [6];
      int modes_snd [6];
      int modes_rcv [6];
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_BASE_ADDRESS;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_INIT;
      req_bus.request_size = '0;
      req_bus.align_log2 = '0;
      req_bus.free_address = '0;
      req_bus.new_end = '0;
      rsp_bus.ready = 1'b1;
      sender_pct = 0;
      receiver_pct = 0;
      requests_sent = 0;
      hold_left = 0;
      hold_wanted = 0;
      hold_done = 0;
      cur_base = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, merge cases, range and corruption checks
      set_arena('0, 17'd4096);
      send_request(CMD_ALLOC, 16'd0, 4'd0, '0, '0);
      send_request(CMD_ALLOC, 16'd64, 4'd3, '0, '0);
      send_request(CMD_ALLOC, 16'd65, 4'd0, '0, '0);
      send_request(CMD_ALLOC, 16'd64, 4'd2, '0, '0);
      send_request(CMD_ALLOC, 16'hFFFF, 4'd0, '0, '0);
      send_request(CMD_ALLOC, 16'd1, 4'd12, '0, '0);
      send_request(CMD_ALLOC, 16'd8, 4'd15, '0, '0);
      wait_idle();
      if (live_blocks.size() >= 4) begin
         send_request(CMD_FREE, '0, '0, live_blocks[2], '0);
         send_request(CMD_FREE, '0, '0, live_blocks[1], '0);
         send_request(CMD_FREE, '0, '0, live_blocks[3], '0);
         send_request(CMD_FREE, '0, '0, live_blocks[3], '0);
      end
      send_request(CMD_FREE, '0, '0, '0, '0);
      send_request(CMD_FREE, '0, '0, 48'd44, '0);
      send_request(CMD_FREE, '0, '0, 48'd16, '0);
      send_request(CMD_FREE, '0, '0, 48'd8192, '0);
      send_request(CMD_FREE, '0, '0, 48'hFFFF_FFFF_FFFF, '0);
      send_request(CMD_EXTEND, '0, '0, '0, 48'd8196);
      send_request(CMD_EXTEND, '0, '0, '0, 48'd65544);
      send_request(CMD_EXTEND, '0, '0, '0, 48'd1024);
      send_request(CMD_EXTEND, '0, '0, '0, 48'd8192);
      send_request(CMD_ALLOC, 16'd60000, 4'd0, '0, '0);
      send_request(CMD_EXTEND, '0, '0, '0, 48'd8200);
      send_request(CMD_EXTEND, '0, '0, '0, 48'd16384);
      send_request(CMD_INIT, '0, '0, '0, '0);
      wait_idle();

      // random phases across arena settings and idling patterns
      bases = '{48'd0, 48'hFFFF_FFFF_FFFF, 48'h0000_1000_0000, 48'hFFFF_FFFF_0000,
                48'h8000_0000_0007, 48'd0};
      sizes = '{17'd4096, 17'd65536, 17'd0, 17'h1FFFF, 17'd32, 17'd2000};
      modes_snd = '{0, 47, 0, 9, 47, 0};
      modes_rcv = '{0, 0, 47, 9, 0, 47};
      bases[2][31:0] = $urandom();
      sizes[5] = 17'($urandom_range(32, 65536));
      for (int ph = 0; ph < 6; ph++) begin
         sender_pct = modes_snd[ph];
         receiver_pct = modes_rcv[ph];
         set_arena(bases[ph], sizes[ph]);
         for (int n = 0; n < 200; n++) begin
            if (ph == 1 && n == 80) hold_wanted = 1;
            random_request();
         end
         wait_idle();
      end
      sender_pct = 0;
      receiver_pct = 0;
      repeat (100) @(posedge clock);

      $display("run covered %0d requests and %0d checked responses", requests_sent, checked);
      $display("one directed layout, six random layouts, 4 idling patterns, one long hold-off");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ffca_pkg.sv
design/ffca_if.sv
design/ffca_mem.sv
design/ffca_engine.sv
design/first_fit_coalescing_allocator.sv
design/ffca_checker.sv
bench/ffca_checker.sv
bench/first_fit_coalescing_allocator_tb.sv
